// ----- src/lsce_pkg.sv -----
`timescale 1ns / 1ps

package lsce_pkg;

	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_HIDDEN = 2'd1,
		OP_TARGET = 2'd2,
		OP_FINISH = 2'd3
	} opcode_t;

	localparam logic [1:0] KIND_ROW   = 2'd0;
	localparam logic [1:0] KIND_MEAN  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] REG_HIDDEN_SIZE   = 2'd0;
	localparam logic [1:0] REG_VOCAB_SIZE    = 2'd1;
	localparam logic [1:0] REG_IGNORE_ENABLE = 2'd2;
	localparam logic [1:0] REG_IGNORE_VALUE  = 2'd3;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam int EXP_STEPS = 20;
	localparam int LN_STEPS  = 20;
	localparam int DIV_STEPS = 49;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAC,
		S_MAC_DRAIN,
		S_EXP_READ,
		S_EXP_LOAD,
		S_EXP_STEP,
		S_EXP_ADD,
		S_LN_INIT,
		S_LN_NORM,
		S_LN_STEP,
		S_LN_SCALE,
		S_LOSS,
		S_DIV,
		S_DIV_END
	} state_t;

	typedef struct packed {
		logic load_weight;
		logic load_hidden;
		logic emit_ignore;
		logic emit_error;
		logic emit_mean_zero;
		logic row_begin;
		logic mac_issue;
		logic exp_load;
		logic exp_step;
		logic exp_add;
		logic ln_init;
		logic ln_norm;
		logic ln_step;
		logic ln_scale;
		logic loss_update;
		logic div_begin;
		logic div_step;
		logic div_end;
	} cmd_t;

	typedef struct packed {
		logic tgt_ignored;
		logic tgt_bad;
		logic rows_zero;
		logic mac_last;
		logic pipe_busy;
		logic exp_bit_last;
		logic exp_row_last;
		logic ln_small;
		logic norm_done;
		logic ln_iter_last;
		logic div_last;
	} sts_t;

	// exp(-2^(b-16)) in Q0.32
	function automatic logic [31:0] exp_factor(input logic [4:0] b);
		logic [31:0] f;
		case (b)
			5'd0:  f = 32'd4294901760;
			5'd1:  f = 32'd4294836226;
			5'd2:  f = 32'd4294705160;
			5'd3:  f = 32'd4294443040;
			5'd4:  f = 32'd4293918848;
			5'd5:  f = 32'd4292870656;
			5'd6:  f = 32'd4290775039;
			5'd7:  f = 32'd4286586875;
			5'd8:  f = 32'd4278222805;
			5'd9:  f = 32'd4261543595;
			5'd10: f = 32'd4228380000;
			5'd11: f = 32'd4162825044;
			5'd12: f = 32'd4034748382;
			5'd13: f = 32'd3790295335;
			5'd14: f = 32'd3344923893;
			5'd15: f = 32'd2605029347;
			5'd16: f = 32'd1580030169;
			5'd17: f = 32'd581260616;
			5'd18: f = 32'd78665070;
			5'd19: f = 32'd1440801;
			default: f = 32'd0;
		endcase
		return f;
	endfunction

endpackage

// ----- src/lsce_ctrl.sv -----
`timescale 1ns / 1ps

module lsce_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  lsce_pkg::sts_t    sts,
	output lsce_pkg::cmd_t    cmd,
	output logic              busy
);

	lsce_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsce_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsce_pkg::S_IDLE: begin
				if (start) begin
					if (opcode == lsce_pkg::OP_TARGET && !sts.tgt_ignored && !sts.tgt_bad)
						state_d = lsce_pkg::S_MAC;
					else if (opcode == lsce_pkg::OP_FINISH && !sts.rows_zero)
						state_d = lsce_pkg::S_DIV;
				end
			end
			lsce_pkg::S_MAC: begin
				if (sts.mac_last) state_d = lsce_pkg::S_MAC_DRAIN;
			end
			lsce_pkg::S_MAC_DRAIN: begin
				if (!sts.pipe_busy) state_d = lsce_pkg::S_EXP_READ;
			end
			lsce_pkg::S_EXP_READ: state_d = lsce_pkg::S_EXP_LOAD;
			lsce_pkg::S_EXP_LOAD: state_d = lsce_pkg::S_EXP_STEP;
			lsce_pkg::S_EXP_STEP: begin
				if (sts.exp_bit_last) state_d = lsce_pkg::S_EXP_ADD;
			end
			lsce_pkg::S_EXP_ADD: begin
				state_d = sts.exp_row_last ? lsce_pkg::S_LN_INIT : lsce_pkg::S_EXP_READ;
			end
			lsce_pkg::S_LN_INIT: begin
				state_d = sts.ln_small ? lsce_pkg::S_LOSS : lsce_pkg::S_LN_NORM;
			end
			lsce_pkg::S_LN_NORM: begin
				if (sts.norm_done) state_d = lsce_pkg::S_LN_STEP;
			end
			lsce_pkg::S_LN_STEP: begin
				if (sts.ln_iter_last) state_d = lsce_pkg::S_LN_SCALE;
			end
			lsce_pkg::S_LN_SCALE: state_d = lsce_pkg::S_LOSS;
			lsce_pkg::S_LOSS: state_d = lsce_pkg::S_IDLE;
			lsce_pkg::S_DIV: begin
				if (sts.div_last) state_d = lsce_pkg::S_DIV_END;
			end
			lsce_pkg::S_DIV_END: state_d = lsce_pkg::S_IDLE;
			default: state_d = lsce_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			lsce_pkg::S_IDLE: begin
				if (start) begin
					unique case (opcode)
						lsce_pkg::OP_WEIGHT: cmd.load_weight = 1'b1;
						lsce_pkg::OP_HIDDEN: cmd.load_hidden = 1'b1;
						lsce_pkg::OP_TARGET: begin
							if (sts.tgt_ignored) cmd.emit_ignore = 1'b1;
							else if (sts.tgt_bad) cmd.emit_error = 1'b1;
							else cmd.row_begin = 1'b1;
						end
						lsce_pkg::OP_FINISH: begin
							if (sts.rows_zero) cmd.emit_mean_zero = 1'b1;
							else cmd.div_begin = 1'b1;
						end
						default: cmd = '0;
					endcase
				end
			end
			lsce_pkg::S_MAC:       cmd.mac_issue = 1'b1;
			lsce_pkg::S_MAC_DRAIN: cmd = '0;
			lsce_pkg::S_EXP_READ:  cmd = '0;
			lsce_pkg::S_EXP_LOAD:  cmd.exp_load = 1'b1;
			lsce_pkg::S_EXP_STEP:  cmd.exp_step = 1'b1;
			lsce_pkg::S_EXP_ADD:   cmd.exp_add = 1'b1;
			lsce_pkg::S_LN_INIT:   cmd.ln_init = 1'b1;
			lsce_pkg::S_LN_NORM:   cmd.ln_norm = 1'b1;
			lsce_pkg::S_LN_STEP:   cmd.ln_step = 1'b1;
			lsce_pkg::S_LN_SCALE:  cmd.ln_scale = 1'b1;
			lsce_pkg::S_LOSS:      cmd.loss_update = 1'b1;
			lsce_pkg::S_DIV:       cmd.div_step = 1'b1;
			lsce_pkg::S_DIV_END:   cmd.div_end = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != lsce_pkg::S_IDLE);

endmodule

// ----- src/lsce_dp.sv -----
`timescale 1ns / 1ps

module lsce_dp #(
	parameter int MAX_HIDDEN = 256,
	parameter int MAX_VOCAB  = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsce_pkg::cmd_t      cmd,
	output lsce_pkg::sts_t      sts,
	input  logic [17:0]         element_index,
	input  logic signed [15:0]  element_value,
	input  logic signed [31:0]  target,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                result_valid,
	output logic [1:0]          result_kind,
	output logic                row_ignored,
	output logic signed [31:0]  row_maximum,
	output logic [31:0]         row_exp_sum,
	output logic [31:0]         mean_loss,
	output logic [23:0]         rows_counted
);

	localparam int HAW    = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
	localparam int VAW    = $clog2(MAX_VOCAB);
	localparam int WDEPTH = MAX_VOCAB * MAX_HIDDEN;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int LW     = 33 + $clog2(MAX_HIDDEN);
	localparam int DW     = LW - 8;
	localparam logic [47:0] LOSS_MAX = '1;
	localparam logic signed [LW-1:0] S32_HI = LW'(2147483647);
	localparam logic signed [LW-1:0] S32_LO = -S32_HI - LW'(1);

	// configuration
	logic [8:0]  hidden_size_q;
	logic [10:0] vocab_size_q;
	logic        ignore_enable_q;
	logic [31:0] ignore_value_q;

	logic [31:0] hs32, vs32, hcnt32, vcnt32, idx32;
	logic [HAW-1:0] hlast;
	logic [VAW-1:0] vlast;

	// storage
	logic signed [15:0] wmem [WDEPTH];
	logic signed [15:0] hmem [MAX_HIDDEN];
	logic [LW-1:0]      lmem [MAX_VOCAB];

	// logit pass
	logic [WAW-1:0] addr_q;
	logic [HAW-1:0] col_q;
	logic [VAW-1:0] row_q, erow_q, tgt_q;
	logic valid_s1, first_s1, last_s1;
	logic [VAW-1:0] row_s1;
	logic signed [15:0] w_s1, h_s1;
	logic valid_s2, first_s2, last_s2;
	logic [VAW-1:0] row_s2;
	logic signed [31:0] prod_s2;
	logic signed [LW-1:0] acc_q, mx_q, tlogit_q, mac_sum;
	logic [LW-1:0] ldata_q;

	// exp pass
	logic [LW-1:0] ediff;
	logic [DW-1:0] ex;
	logic [19:0] xarg_q;
	logic        big_q;
	logic [32:0] eacc_q;
	logic [4:0]  bit_q;
	logic [64:0] emul, erd;
	logic [33:0] eround;
	logic [17:0] eterm;
	logic [32:0] esum_q;
	logic [31:0] esat;

	// log
	logic [31:0] esat_q, norm_q;
	logic [4:0]  top_q;
	logic [30:0] m_q;
	logic [19:0] frac_q;
	logic [4:0]  iter_q;
	logic [61:0] lsq;
	logic [31:0] lt;
	logic [55:0] lnprod_q;
	logic [56:0] lnround;

	// loss and mean
	logic [47:0] loss_q;
	logic [23:0] rows_q, rows_inc;
	logic [LW-1:0] tdiff;
	logic [49:0] lsum;
	logic signed [LW-1:0] mr;
	logic [31:0] rmax;
	logic [48:0] quo_q;
	logic [23:0] rem_q;
	logic [5:0]  dcnt_q;
	logic [24:0] dr, dsub;
	logic        dge;

	assign hs32   = 32'(hidden_size_q);
	assign vs32   = 32'(vocab_size_q);
	assign hcnt32 = (hs32 == 32'd0) ? 32'd1 :
		((hs32 > 32'(MAX_HIDDEN)) ? 32'(MAX_HIDDEN) : hs32);
	assign vcnt32 = (vs32 == 32'd0) ? 32'd1 :
		((vs32 > 32'(MAX_VOCAB)) ? 32'(MAX_VOCAB) : vs32);
	assign hlast  = HAW'(hcnt32 - 32'd1);
	assign vlast  = VAW'(vcnt32 - 32'd1);
	assign idx32  = 32'(element_index);

	assign mac_sum = (first_s2 ? LW'(0) : acc_q) + LW'(prod_s2);

	assign ediff  = LW'(mx_q - $signed(ldata_q)) + LW'(128);
	assign ex     = ediff[LW-1:8];
	assign emul   = 65'(eacc_q) * 65'(lsce_pkg::exp_factor(bit_q));
	assign erd    = emul + 65'(33'h0_8000_0000);
	assign eround = 34'(eacc_q) + 34'd32768;
	assign eterm  = big_q ? 18'd0 : eround[33:16];
	assign esat   = esum_q[32] ? 32'hFFFF_FFFF : esum_q[31:0];

	assign lsq     = 62'(m_q) * 62'(m_q);
	assign lt      = lsq[61:30];
	assign lnround = 57'(lnprod_q) + (57'(1) << 35);

	assign tdiff    = LW'(mx_q - tlogit_q) + LW'(128);
	assign lsum     = 50'(loss_q) + 50'(tdiff[LW-1:8]) + 50'(lnround[56:36]);
	assign rows_inc = (rows_q == 24'hFF_FFFF) ? rows_q : rows_q + 24'd1;
	assign mr       = (mx_q + LW'(128)) >>> 8;
	assign rmax     = (mr > S32_HI) ? 32'h7FFF_FFFF :
		((mr < S32_LO) ? 32'h8000_0000 : mr[31:0]);

	assign dr   = {rem_q, quo_q[48]};
	assign dsub = dr - {1'b0, rows_q};
	assign dge  = (dr >= {1'b0, rows_q});

	always_comb begin
		sts = '0;
		sts.tgt_ignored  = ignore_enable_q && (target == $signed(ignore_value_q));
		sts.tgt_bad      = target[31] || ($unsigned(target) >= vcnt32);
		sts.rows_zero    = (rows_q == 24'd0);
		sts.mac_last     = (row_q == vlast) && (col_q == hlast);
		sts.pipe_busy    = valid_s1 | valid_s2;
		sts.exp_bit_last = (bit_q == 5'(lsce_pkg::EXP_STEPS - 1));
		sts.exp_row_last = (erow_q == vlast);
		sts.ln_small     = (esat[31:16] == 16'd0);
		sts.norm_done    = norm_q[31];
		sts.ln_iter_last = (iter_q == 5'(lsce_pkg::LN_STEPS - 1));
		sts.div_last     = (dcnt_q == 6'(lsce_pkg::DIV_STEPS - 1));
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load_weight && idx32 < 32'(WDEPTH))
			wmem[idx32[WAW-1:0]] <= element_value;
		w_s1 <= wmem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hidden && idx32 < 32'(MAX_HIDDEN))
			hmem[idx32[HAW-1:0]] <= element_value;
		h_s1 <= hmem[col_q];
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2)
			lmem[row_s2] <= mac_sum;
		ldata_q <= lmem[erow_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidden_size_q   <= 9'd256;
			vocab_size_q    <= 11'd1024;
			ignore_enable_q <= 1'b0;
			ignore_value_q  <= 32'hFFFF_FF9C;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			addr_q          <= '0;
			col_q           <= '0;
			row_q           <= '0;
			erow_q          <= '0;
			bit_q           <= '0;
			iter_q          <= '0;
			dcnt_q          <= '0;
			loss_q          <= '0;
			rows_q          <= '0;
			result_valid    <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					lsce_pkg::REG_HIDDEN_SIZE:   hidden_size_q   <= cfg_data[8:0];
					lsce_pkg::REG_VOCAB_SIZE:    vocab_size_q    <= cfg_data[10:0];
					lsce_pkg::REG_IGNORE_ENABLE: ignore_enable_q <= cfg_data[0];
					lsce_pkg::REG_IGNORE_VALUE:  ignore_value_q  <= cfg_data;
					default: ignore_value_q <= ignore_value_q;
				endcase
			end
			valid_s1 <= cmd.mac_issue;
			valid_s2 <= valid_s1;
			if (cmd.row_begin) begin
				addr_q <= '0;
				col_q  <= '0;
				row_q  <= '0;
				erow_q <= '0;
			end
			if (cmd.mac_issue) begin
				addr_q <= addr_q + WAW'(1);
				if (col_q == hlast) begin
					col_q <= '0;
					row_q <= row_q + VAW'(1);
				end else begin
					col_q <= col_q + HAW'(1);
				end
			end
			if (cmd.exp_load) bit_q <= '0;
			if (cmd.exp_step) bit_q <= bit_q + 5'd1;
			if (cmd.exp_add) erow_q <= erow_q + VAW'(1);
			if (cmd.ln_norm && norm_q[31]) iter_q <= '0;
			if (cmd.ln_step) iter_q <= iter_q + 5'd1;
			if (cmd.div_begin) dcnt_q <= '0;
			if (cmd.div_step) dcnt_q <= dcnt_q + 6'd1;
			if (cmd.loss_update) begin
				loss_q <= (lsum > 50'(LOSS_MAX)) ? LOSS_MAX : lsum[47:0];
				rows_q <= rows_inc;
			end
			if (cmd.emit_error || cmd.emit_mean_zero || cmd.div_end) begin
				loss_q <= '0;
				rows_q <= '0;
			end
			result_valid <= cmd.emit_ignore | cmd.emit_error | cmd.emit_mean_zero |
				cmd.loss_update | cmd.div_end;
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		first_s1 <= (col_q == '0);
		last_s1  <= (col_q == hlast);
		row_s1   <= row_q;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		prod_s2  <= w_s1 * h_s1;

		if (cmd.row_begin) begin
			tgt_q  <= target[VAW-1:0];
			esum_q <= '0;
		end
		if (valid_s2) begin
			acc_q <= mac_sum;
			if (last_s2) begin
				if (row_s2 == '0 || mac_sum > mx_q) mx_q <= mac_sum;
				if (row_s2 == tgt_q) tlogit_q <= mac_sum;
			end
		end

		if (cmd.exp_load) begin
			xarg_q <= ex[19:0];
			big_q  <= |ex[DW-1:20];
			eacc_q <= 33'h1_0000_0000;
		end
		if (cmd.exp_step && xarg_q[bit_q]) eacc_q <= erd[64:32];
		if (cmd.exp_add) esum_q <= esum_q + 33'(eterm);

		if (cmd.ln_init) begin
			esat_q   <= esat;
			norm_q   <= esat;
			top_q    <= 5'd31;
			lnprod_q <= '0;
		end
		if (cmd.ln_norm) begin
			if (norm_q[31]) begin
				m_q    <= norm_q[31:1];
				frac_q <= '0;
			end else begin
				norm_q <= {norm_q[30:0], 1'b0};
				top_q  <= top_q - 5'd1;
			end
		end
		if (cmd.ln_step) begin
			m_q    <= lt[31] ? lt[31:1] : lt[30:0];
			frac_q <= {frac_q[18:0], lt[31]};
		end
		if (cmd.ln_scale)
			lnprod_q <= 56'({4'(top_q - 5'd16), frac_q}) * 56'(lsce_pkg::LN2_Q32);

		if (cmd.div_begin) begin
			quo_q <= 49'(loss_q) + 49'(rows_q >> 1);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= dge ? dsub[23:0] : dr[23:0];
			quo_q <= {quo_q[47:0], dge};
		end

		if (cmd.emit_ignore) begin
			result_kind  <= lsce_pkg::KIND_ROW;
			row_ignored  <= 1'b1;
			row_maximum  <= '0;
			row_exp_sum  <= 32'd65536;
			mean_loss    <= '0;
			rows_counted <= rows_q;
		end
		if (cmd.emit_error) begin
			result_kind  <= lsce_pkg::KIND_ERROR;
			row_ignored  <= 1'b0;
			row_maximum  <= '0;
			row_exp_sum  <= '0;
			mean_loss    <= '0;
			rows_counted <= '0;
		end
		if (cmd.emit_mean_zero) begin
			result_kind  <= lsce_pkg::KIND_MEAN;
			row_ignored  <= 1'b0;
			row_maximum  <= '0;
			row_exp_sum  <= '0;
			mean_loss    <= '0;
			rows_counted <= '0;
		end
		if (cmd.loss_update) begin
			result_kind  <= lsce_pkg::KIND_ROW;
			row_ignored  <= 1'b0;
			row_maximum  <= rmax;
			row_exp_sum  <= esat_q;
			mean_loss    <= '0;
			rows_counted <= rows_inc;
		end
		if (cmd.div_end) begin
			result_kind  <= lsce_pkg::KIND_MEAN;
			row_ignored  <= 1'b0;
			row_maximum  <= '0;
			row_exp_sum  <= '0;
			mean_loss    <= (|quo_q[48:32]) ? 32'hFFFF_FFFF : quo_q[31:0];
			rows_counted <= rows_q;
		end
	end

endmodule

// ----- src/linear_softmax_cross_entropy.sv -----
`timescale 1ns / 1ps

// Forward linear layer, softmax and cross-entropy loss. Weight and hidden loads
// give no result. A row target of V vocabulary rows of H hidden elements runs a
// logit pass that does one product a cycle through the weight memory read port,
// and each logit then goes through the shared exp multiplier before the log. A
// finish with counted rows runs through the bit-serial divider. Ignored rows,
// out-of-range targets and finishes with no counted rows give their result in
// the cycle after the transfer.
// busy is high while a row or a mean is in work. Each result shows for one cycle
// with result_valid and cannot be stalled; the receiver must take it.
module linear_softmax_cross_entropy #(
	parameter int MAX_HIDDEN = 256,
	parameter int MAX_VOCAB  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [17:0]        element_index,
	input  logic signed [15:0] element_value,
	input  logic signed [31:0] target,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               result_valid,
	output logic [1:0]         result_kind,
	output logic               row_ignored,
	output logic signed [31:0] row_maximum,
	output logic [31:0]        row_exp_sum,
	output logic [31:0]        mean_loss,
	output logic [23:0]        rows_counted
);

	lsce_pkg::cmd_t cmd;
	lsce_pkg::sts_t sts;

	lsce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lsce_dp #(
		.MAX_HIDDEN (MAX_HIDDEN),
		.MAX_VOCAB  (MAX_VOCAB)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.element_index (element_index),
		.element_value (element_value),
		.target        (target),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.result_kind   (result_kind),
		.row_ignored   (row_ignored),
		.row_maximum   (row_maximum),
		.row_exp_sum   (row_exp_sum),
		.mean_loss     (mean_loss),
		.rows_counted  (rows_counted)
	);

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == lsce_pkg::OP_WEIGHT || opcode == lsce_pkg::OP_HIDDEN))
		|=> !result_valid)
		else $error("load transfer produced a result");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == lsce_pkg::KIND_ERROR)
		|-> (rows_counted == 24'd0 && row_maximum == 32'sd0 && row_exp_sum == 32'd0))
		else $error("error result carries data");

	a_ignored_row: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && row_ignored)
		|-> (result_kind == lsce_pkg::KIND_ROW && row_exp_sum == 32'd65536))
		else $error("ignored row result malformed");

	a_busy_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy)
		|-> $past(start && (opcode == lsce_pkg::OP_TARGET || opcode == lsce_pkg::OP_FINISH)))
		else $error("busy raised without a row or finish transfer");

endmodule
